>>> rtl/confusion_matrix_accumulator_macros.svh
// ----------------------------------------------------------------------------
// Confusion matrix accumulator assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef CONFUSION_MATRIX_ACCUMULATOR_MACROS_SVH
`define CONFUSION_MATRIX_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define CMA_ASSERT_HOLD(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, also checked across reset.
`define CMA_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/cma_pkg.sv
// ----------------------------------------------------------------------------
// Confusion matrix accumulator package
// Sizes, codes, word types and the saturating increment shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package cma_pkg;

   localparam int MAX_CLASSES       = 16;
   localparam int CLASS_W           = $clog2(MAX_CLASSES);
   localparam int CELLS             = MAX_CLASSES * MAX_CLASSES;
   localparam int CELL_ADDR_W       = 2 * CLASS_W;
   localparam int COUNT_W           = 32;
   localparam int SCORE_W           = 16;
   localparam int NUMC_W            = 5;
   localparam int NUM_CLASSES_RESET = 16;
   localparam int NUM_CLASSES_MIN   = 2;

   localparam int OP_DEPTH          = 4;
   localparam int OP_PTR_W          = $clog2(OP_DEPTH);
   localparam int OP_CNT_W          = $clog2(OP_DEPTH + 1);

   localparam int RSP_DEPTH         = 2;
   localparam int RSP_PTR_W         = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W         = $clog2(RSP_DEPTH + 1);

   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_IDX_LSB       = 2;

   // Register index decoded from the configuration address.
   localparam logic REG_NUM_CLASSES = 1'b0;

   typedef enum logic [1:0] {
      FUNC_SCORE       = 2'd0,
      FUNC_QUERY_CLASS = 2'd1,
      FUNC_QUERY_CELL  = 2'd2,
      FUNC_CLEAR       = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_EVENT = 2'd0,
      KIND_CLASS = 2'd1,
      KIND_CELL  = 2'd2
   } kind_type;

   // Operation handed from the front to the back. A FUNC_SCORE operation is
   // an event commit for the cell (row, col).
   typedef struct packed {
      func_type             code;
      logic [CLASS_W-1:0]   row;
      logic [CLASS_W-1:0]   col;
   } op_type;

   typedef struct packed {
      kind_type             kind;
      logic [CLASS_W-1:0]   actual_class;
      logic [CLASS_W-1:0]   predicted_class;
      logic [COUNT_W-1:0]   cell_count;
      logic [COUNT_W-1:0]   correct_count;
      logic [COUNT_W-1:0]   row_miss_count;
      logic [COUNT_W-1:0]   col_wrong_count;
      logic [COUNT_W-1:0]   total_count;
      logic [COUNT_W-1:0]   correct_total;
      logic                 saturated;
   } rsp_type;

   // Adds one unless the counter already holds its maximum.
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      sat_inc = (&c) ? c : c + COUNT_W'(1);
   endfunction

endpackage

`default_nettype wire

>>> rtl/cma_front.sv
// ----------------------------------------------------------------------------
// Confusion matrix accumulator front end
// Accepts words, tracks the running argmax and issues operations.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   output      logic                              full,
   input  wire logic [1:0]                        func,
   input  wire logic signed [cma_pkg::SCORE_W-1:0] predicted_score,
   input  wire logic signed [cma_pkg::SCORE_W-1:0] actual_score,
   input  wire logic [cma_pkg::CLASS_W-1:0]       class_index,
   input  wire logic [cma_pkg::CLASS_W-1:0]       other_index,
   input  wire logic [cma_pkg::NUMC_W-1:0]        num_classes,
   input  wire logic                              op_full,
   output      logic                              op_push,
   output      cma_pkg::op_type                   op_data
);
   import cma_pkg::*;

   logic [CLASS_W-1:0]        pos_ff, pos_in;
   logic signed [SCORE_W-1:0] best_p_ff, best_p_in;
   logic signed [SCORE_W-1:0] best_a_ff, best_a_in;
   logic [CLASS_W-1:0]        best_pi_ff, best_pi_in;
   logic [CLASS_W-1:0]        best_ai_ff, best_ai_in;

   logic [NUMC_W-1:0]         n_use;
   logic                      last_pos;
   logic                      take_p;
   logic                      take_a;
   logic                      accept;

   assign full   = op_full;
   assign accept = push && !op_full;

   always_comb begin
      if (num_classes < NUMC_W'(NUM_CLASSES_MIN)) begin
         n_use = NUMC_W'(NUM_CLASSES_MIN);
      end else if (num_classes > NUMC_W'(MAX_CLASSES)) begin
         n_use = NUMC_W'(MAX_CLASSES);
      end else begin
         n_use = num_classes;
      end
   end

   assign last_pos = (NUMC_W'(pos_ff) + NUMC_W'(1)) >= n_use;
   assign take_p   = (pos_ff == '0) || (predicted_score > best_p_ff);
   assign take_a   = (pos_ff == '0) || (actual_score > best_a_ff);

   always_comb begin
      pos_in     = pos_ff;
      best_p_in  = best_p_ff;
      best_a_in  = best_a_ff;
      best_pi_in = best_pi_ff;
      best_ai_in = best_ai_ff;
      op_push    = 1'b0;
      op_data    = '{code: func_type'(func), row: class_index, col: other_index};
      if (accept) begin
         case (func_type'(func))
            FUNC_SCORE: begin
               if (take_p) begin
                  best_p_in  = predicted_score;
                  best_pi_in = pos_ff;
               end
               if (take_a) begin
                  best_a_in  = actual_score;
                  best_ai_in = pos_ff;
               end
               if (last_pos) begin
                  pos_in      = '0;
                  op_push     = 1'b1;
                  op_data.row = best_ai_in;
                  op_data.col = best_pi_in;
               end else begin
                  pos_in = pos_ff + CLASS_W'(1);
               end
            end
            FUNC_QUERY_CLASS: begin
               op_push     = 1'b1;
               op_data.col = class_index;
            end
            FUNC_QUERY_CELL: begin
               op_push = 1'b1;
            end
            FUNC_CLEAR: begin
               op_push    = 1'b1;
               pos_in     = '0;
               best_p_in  = '0;
               best_a_in  = '0;
               best_pi_in = '0;
               best_ai_in = '0;
            end
            default: begin
               op_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         best_p_ff  <= '0;
         best_a_ff  <= '0;
         best_pi_ff <= '0;
         best_ai_ff <= '0;
      end else begin
         pos_ff     <= pos_in;
         best_p_ff  <= best_p_in;
         best_a_ff  <= best_a_in;
         best_pi_ff <= best_pi_in;
         best_ai_ff <= best_ai_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/cma_op_queue.sv
// ----------------------------------------------------------------------------
// Confusion matrix accumulator operation queue
// Short first-in first-out store between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_op_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire cma_pkg::op_type data_in,
   output      logic            full,
   input  wire logic            pop,
   output      cma_pkg::op_type data_out,
   output      logic            empty
);
   import cma_pkg::*;

   op_type               slot_ff [OP_DEPTH];
   logic [OP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [OP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [OP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (cnt_ff == OP_CNT_W'(OP_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + OP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + OP_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + OP_CNT_W'(do_push) - OP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/cma_back.sv
// ----------------------------------------------------------------------------
// Confusion matrix accumulator back end
// Holds the matrix and counters, carries out operations, queues results.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             op_empty,
   input  wire cma_pkg::op_type  op_data,
   output      logic             op_pop,
   input  wire logic             pop,
   output      logic             empty,
   output      cma_pkg::rsp_type rsp_data
);
   import cma_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } back_state_type;

   back_state_type        state_ff, state_in;
   op_type                op_ff;

   // Matrix store: one write and one registered read per cycle. The valid
   // bits stand for the zero left by reset or clear.
   logic [COUNT_W-1:0]    matrix_mem [CELLS];
   logic [COUNT_W-1:0]    rd_data_ff;
   logic                  rd_hit_ff;
   logic [CELLS-1:0]      cell_valid_ff, cell_valid_in;
   logic [CELL_ADDR_W-1:0] rd_addr;
   logic [CELL_ADDR_W-1:0] wr_addr;
   logic                  mem_we;

   logic [COUNT_W-1:0]    row_miss_ff  [MAX_CLASSES];
   logic [COUNT_W-1:0]    row_miss_in  [MAX_CLASSES];
   logic [COUNT_W-1:0]    col_wrong_ff [MAX_CLASSES];
   logic [COUNT_W-1:0]    col_wrong_in [MAX_CLASSES];
   logic [COUNT_W-1:0]    event_ff, event_in;
   logic [COUNT_W-1:0]    diag_ff, diag_in;
   logic                  sat_ff, sat_in;

   logic [COUNT_W-1:0]    cell_old;
   logic [COUNT_W-1:0]    cell_new;
   logic                  is_diag;

   rsp_type               rq_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  rq_wr_ff, rq_wr_in;
   logic [RSP_PTR_W-1:0]  rq_rd_ff, rq_rd_in;
   logic [RSP_CNT_W-1:0]  rq_cnt_ff, rq_cnt_in;
   logic                  rq_push;
   logic                  rq_pop;
   rsp_type               res;

   assign rd_addr  = {op_data.row, op_data.col};
   assign wr_addr  = {op_ff.row, op_ff.col};
   assign cell_old = rd_hit_ff ? rd_data_ff : '0;
   assign cell_new = sat_inc(cell_old);
   assign is_diag  = (op_ff.row == op_ff.col);

   assign empty    = (rq_cnt_ff == '0);
   assign rq_pop   = pop && !empty;
   assign rsp_data = rq_ff[rq_rd_ff];

   always_comb begin
      state_in      = state_ff;
      op_pop        = 1'b0;
      mem_we        = 1'b0;
      rq_push       = 1'b0;
      cell_valid_in = cell_valid_ff;
      row_miss_in   = row_miss_ff;
      col_wrong_in  = col_wrong_ff;
      event_in      = event_ff;
      diag_in       = diag_ff;
      sat_in        = sat_ff;
      res           = '0;
      res.kind            = KIND_CELL;
      res.actual_class    = op_ff.row;
      res.predicted_class = op_ff.col;
      res.cell_count      = cell_old;
      res.total_count     = event_ff;
      res.correct_total   = diag_ff;
      res.saturated       = sat_ff;
      case (state_ff)
         ST_IDLE: begin
            // The result queue always keeps a place for the operation taken.
            if (!op_empty && (rq_cnt_ff != RSP_CNT_W'(RSP_DEPTH))) begin
               op_pop   = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (op_ff.code)
               FUNC_SCORE: begin
                  mem_we                 = 1'b1;
                  cell_valid_in[wr_addr] = 1'b1;
                  event_in               = sat_inc(event_ff);
                  if (is_diag) begin
                     diag_in = sat_inc(diag_ff);
                     sat_in  = sat_ff | (&cell_old) | (&diag_ff) | (&event_ff);
                  end else begin
                     row_miss_in[op_ff.row]  = sat_inc(row_miss_ff[op_ff.row]);
                     col_wrong_in[op_ff.col] = sat_inc(col_wrong_ff[op_ff.col]);
                     sat_in = sat_ff | (&cell_old) | (&row_miss_ff[op_ff.row])
                            | (&col_wrong_ff[op_ff.col]) | (&event_ff);
                  end
                  rq_push           = 1'b1;
                  res.kind          = KIND_EVENT;
                  res.cell_count    = cell_new;
                  res.total_count   = event_in;
                  res.correct_total = diag_in;
                  res.saturated     = sat_in;
               end
               FUNC_QUERY_CLASS: begin
                  rq_push             = 1'b1;
                  res.kind            = KIND_CLASS;
                  res.correct_count   = cell_old;
                  res.row_miss_count  = row_miss_ff[op_ff.row];
                  res.col_wrong_count = col_wrong_ff[op_ff.row];
               end
               FUNC_QUERY_CELL: begin
                  rq_push = 1'b1;
               end
               FUNC_CLEAR: begin
                  cell_valid_in = '0;
                  event_in      = '0;
                  diag_in       = '0;
                  sat_in        = 1'b0;
                  for (int i = 0; i < MAX_CLASSES; i++) begin
                     row_miss_in[i]  = '0;
                     col_wrong_in[i] = '0;
                  end
               end
               default: begin
                  rq_push = 1'b0;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rq_wr_in  = rq_push ? rq_wr_ff + RSP_PTR_W'(1) : rq_wr_ff;
      rq_rd_in  = rq_pop  ? rq_rd_ff + RSP_PTR_W'(1) : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff + RSP_CNT_W'(rq_push) - RSP_CNT_W'(rq_pop);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         matrix_mem[wr_addr] <= cell_new;
      end
      if (op_pop) begin
         rd_data_ff <= matrix_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         op_ff     <= op_data;
         rd_hit_ff <= cell_valid_ff[rd_addr];
      end
      if (rq_push) begin
         rq_ff[rq_wr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cell_valid_ff <= '0;
         event_ff      <= '0;
         diag_ff       <= '0;
         sat_ff        <= 1'b0;
         rq_wr_ff      <= '0;
         rq_rd_ff      <= '0;
         rq_cnt_ff     <= '0;
         for (int i = 0; i < MAX_CLASSES; i++) begin
            row_miss_ff[i]  <= '0;
            col_wrong_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         cell_valid_ff <= cell_valid_in;
         event_ff      <= event_in;
         diag_ff       <= diag_in;
         sat_ff        <= sat_in;
         rq_wr_ff      <= rq_wr_in;
         rq_rd_ff      <= rq_rd_in;
         rq_cnt_ff     <= rq_cnt_in;
         row_miss_ff   <= row_miss_in;
         col_wrong_ff  <= col_wrong_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/confusion_matrix_accumulator.sv
// ----------------------------------------------------------------------------
// Confusion matrix accumulator
// Argmax per event over streamed class scores, with a saturating 16 by 16
// confusion matrix, per-class miss counters and totals.
// ----------------------------------------------------------------------------
//
//   Channel    Ports                         Word accepted when
//   --------   ---------------------------   -------------------------------
//   request    push, full, req_*             push high and full low
//   response   pop, empty, rsp_*             pop high and empty low
//   register   psel, penable, pwrite, ...    psel, penable, pwrite, pready
//
// A score word that does not end an event never touches the back end, so
// such words stream at one per cycle while full is low.
// Every word that reaches the back end (event commit, query or clear) is
// taken in ST_IDLE, which reads its matrix cell, and carried out in ST_EXEC,
// which writes an event's cell and queues any result; none is taken meanwhile.
// A four-word operation queue lets the front keep accepting while the back
// works; full rises only when that queue is full.
// Reset is synchronous; the matrix is cleared at once through its valid
// bits, so no clearing pass follows.
// A response held by a low pop stalls the back only once both words of the
// result queue are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module confusion_matrix_accumulator (
   input  wire logic                                clock,
   input  wire logic                                reset,

   // Request channel.
   input  wire logic                                push,
   output      logic                                full,
   input  wire logic [1:0]                          req_func,
   input  wire logic signed [cma_pkg::SCORE_W-1:0]  req_predicted_score,
   input  wire logic signed [cma_pkg::SCORE_W-1:0]  req_actual_score,
   input  wire logic [cma_pkg::CLASS_W-1:0]         req_class_index,
   input  wire logic [cma_pkg::CLASS_W-1:0]         req_other_index,

   // Response channel.
   input  wire logic                                pop,
   output      logic                                empty,
   output      logic [1:0]                          rsp_kind,
   output      logic [cma_pkg::CLASS_W-1:0]         rsp_actual_class,
   output      logic [cma_pkg::CLASS_W-1:0]         rsp_predicted_class,
   output      logic [cma_pkg::COUNT_W-1:0]         rsp_cell_count,
   output      logic [cma_pkg::COUNT_W-1:0]         rsp_correct_count,
   output      logic [cma_pkg::COUNT_W-1:0]         rsp_row_miss_count,
   output      logic [cma_pkg::COUNT_W-1:0]         rsp_col_wrong_count,
   output      logic [cma_pkg::COUNT_W-1:0]         rsp_total_count,
   output      logic [cma_pkg::COUNT_W-1:0]         rsp_correct_total,
   output      logic                                rsp_saturated,

   // Register port.
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [cma_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [cma_pkg::CSR_DATA_W-1:0]      pwdata,
   output      logic [cma_pkg::CSR_DATA_W-1:0]      prdata,
   output      logic                                pready
);
   import cma_pkg::*;

   logic [NUMC_W-1:0] num_classes_ff, num_classes_in;
   logic              reg_sel;
   logic              reg_write;

   op_type            front_op;
   logic              front_push;
   logic              op_full;
   op_type            queue_op;
   logic              queue_empty;
   logic              back_pop;
   rsp_type           rsp_word;

   // The register index is the word address; byte offsets are ignored.
   assign pready    = 1'b1;
   assign reg_sel   = (paddr[CSR_IDX_LSB] == REG_NUM_CLASSES);
   assign reg_write = psel && penable && pwrite && pready && reg_sel;

   always_comb begin
      num_classes_in = reg_write ? pwdata[NUMC_W-1:0] : num_classes_ff;
      prdata         = reg_sel ? CSR_DATA_W'(num_classes_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_classes_ff <= NUMC_W'(NUM_CLASSES_RESET);
      end else begin
         num_classes_ff <= num_classes_in;
      end
   end

   // Front end: argmax over the class positions of an event, and the
   // translation of every other word into an operation for the back end.
   cma_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .func            (req_func),
      .predicted_score (req_predicted_score),
      .actual_score    (req_actual_score),
      .class_index     (req_class_index),
      .other_index     (req_other_index),
      .num_classes     (num_classes_ff),
      .op_full         (op_full),
      .op_push         (front_push),
      .op_data         (front_op)
   );

   cma_op_queue u_op_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .data_in  (front_op),
      .full     (op_full),
      .pop      (back_pop),
      .data_out (queue_op),
      .empty    (queue_empty)
   );

   // Back end: matrix, counters and the result queue feeding the outputs.
   cma_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_empty (queue_empty),
      .op_data  (queue_op),
      .op_pop   (back_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_word)
   );

   assign rsp_kind            = rsp_word.kind;
   assign rsp_actual_class    = rsp_word.actual_class;
   assign rsp_predicted_class = rsp_word.predicted_class;
   assign rsp_cell_count      = rsp_word.cell_count;
   assign rsp_correct_count   = rsp_word.correct_count;
   assign rsp_row_miss_count  = rsp_word.row_miss_count;
   assign rsp_col_wrong_count = rsp_word.col_wrong_count;
   assign rsp_total_count     = rsp_word.total_count;
   assign rsp_correct_total   = rsp_word.correct_total;
   assign rsp_saturated       = rsp_word.saturated;

endmodule

`default_nettype wire

>>> rtl/cma_checker.sv
// ----------------------------------------------------------------------------
// Confusion matrix accumulator port checker
// Watches the top-level ports and flags inconsistent responses.
// ----------------------------------------------------------------------------
`default_nettype none

`include "confusion_matrix_accumulator_macros.svh"

module cma_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        full,
   input wire logic                        empty,
   input wire logic [1:0]                  rsp_kind,
   input wire logic [cma_pkg::CLASS_W-1:0] rsp_actual_class,
   input wire logic [cma_pkg::CLASS_W-1:0] rsp_predicted_class,
   input wire logic [cma_pkg::COUNT_W-1:0] rsp_cell_count,
   input wire logic [cma_pkg::COUNT_W-1:0] rsp_correct_count,
   input wire logic [cma_pkg::COUNT_W-1:0] rsp_total_count,
   input wire logic [cma_pkg::COUNT_W-1:0] rsp_correct_total
);
   import cma_pkg::*;

   // Both queues are empty straight after reset.
   `CMA_ASSERT_NEXT(a_reset_idle, clock, reset, empty && !full, "queues not empty after reset")

   // A committed event has just incremented its cell.
   `CMA_ASSERT_HOLD(a_commit_nonzero, clock, reset, !empty && (rsp_kind == KIND_EVENT), rsp_cell_count != '0, "committed cell reads zero")

   // A class answer reports the diagonal cell of that class.
   `CMA_ASSERT_HOLD(a_class_diag, clock, reset, !empty && (rsp_kind == KIND_CLASS), (rsp_actual_class == rsp_predicted_class) && (rsp_cell_count == rsp_correct_count), "class answer not on the diagonal")

   // Correct events never outnumber all events.
   `CMA_ASSERT_HOLD(a_totals_order, clock, reset, !empty, rsp_correct_total <= rsp_total_count, "correct total exceeds event total")

   // Only the three result kinds are ever shown.
   `CMA_ASSERT_HOLD(a_kind_legal, clock, reset, !empty, (rsp_kind == KIND_EVENT) || (rsp_kind == KIND_CLASS) || (rsp_kind == KIND_CELL), "unknown result kind")

endmodule

bind confusion_matrix_accumulator cma_checker u_cma_checker (.*);

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Confusion matrix accumulator testbench
// Streams score, query and clear words into the block and predicts every
// answer from its own model of the argmax, the matrix and the counters. Each
// answer that the block gives is checked field by field against the oldest
// prediction. The number of classes is changed between phases, and both
// sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cma_pkg::*;

   // Longest stretch without any accepted word before the run is abandoned.
   // The receiver hold-off of the pressure test is the longest expected quiet
   // spell, so this leaves ample margin.
   localparam int WATCHDOG_LIMIT  = 3000;
   // Cycles allowed for words still inside the block after the last answer:
   // four queued operations plus the answer queue.
   localparam int SETTLE_CYCLES   = 24;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WORDS_PER_PHASE = 230;
   localparam int MAX_GAP         = 30;
   localparam logic [CSR_ADDR_W-1:0] CLASSES_ADDR =
      CSR_ADDR_W'(REG_NUM_CLASSES) << CSR_IDX_LSB;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [1:0]            req_func = FUNC_SCORE;
   logic signed [SCORE_W-1:0] req_predicted_score = '0;
   logic signed [SCORE_W-1:0] req_actual_score = '0;
   logic [CLASS_W-1:0]    req_class_index = '0;
   logic [CLASS_W-1:0]    req_other_index = '0;
   logic                  pop = 1'b0;
   logic                  empty;
   logic [1:0]            rsp_kind;
   logic [CLASS_W-1:0]    rsp_actual_class;
   logic [CLASS_W-1:0]    rsp_predicted_class;
   logic [COUNT_W-1:0]    rsp_cell_count;
   logic [COUNT_W-1:0]    rsp_correct_count;
   logic [COUNT_W-1:0]    rsp_row_miss_count;
   logic [COUNT_W-1:0]    rsp_col_wrong_count;
   logic [COUNT_W-1:0]    rsp_total_count;
   logic [COUNT_W-1:0]    rsp_correct_total;
   logic                  rsp_saturated;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   confusion_matrix_accumulator DUT (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_func            (req_func),
      .req_predicted_score (req_predicted_score),
      .req_actual_score    (req_actual_score),
      .req_class_index     (req_class_index),
      .req_other_index     (req_other_index),
      .pop                 (pop),
      .empty               (empty),
      .rsp_kind            (rsp_kind),
      .rsp_actual_class    (rsp_actual_class),
      .rsp_predicted_class (rsp_predicted_class),
      .rsp_cell_count      (rsp_cell_count),
      .rsp_correct_count   (rsp_correct_count),
      .rsp_row_miss_count  (rsp_row_miss_count),
      .rsp_col_wrong_count (rsp_col_wrong_count),
      .rsp_total_count     (rsp_total_count),
      .rsp_correct_total   (rsp_correct_total),
      .rsp_saturated       (rsp_saturated),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Model of the block. The tallies mirror the matrix and counters inside
   // the block; the lead scores and slots follow the argmax of the event in
   // progress. Every accepted word passes through tally_step, and each word
   // that produces an answer leaves its prediction in tally_replies.
   // ------------------------------------------------------------------------
   logic [NUMC_W-1:0]         class_setting;
   int                        slot;
   logic signed [SCORE_W-1:0] lead_pred_score;
   logic signed [SCORE_W-1:0] lead_act_score;
   logic [CLASS_W-1:0]        lead_pred_slot;
   logic [CLASS_W-1:0]        lead_act_slot;
   logic [COUNT_W-1:0]        tally_matrix [CELLS];
   logic [COUNT_W-1:0]        miss_by_actual [MAX_CLASSES];
   logic [COUNT_W-1:0]        wrong_by_predicted [MAX_CLASSES];
   logic [COUNT_W-1:0]        events_counted;
   logic [COUNT_W-1:0]        diagonal_counted;
   logic                      overflow_seen;
   rsp_type                   tally_replies [$];

   // Test controls and run statistics.
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   bit hold_off_requested = 1'b0;
   int hold_left = 0;
   int words_sent = 0;
   int replies_seen = 0;
   int events_seen = 0;
   int stalled_cycles = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   task automatic clear_tallies();
      slot = 0;
      lead_pred_score = '0;
      lead_act_score = '0;
      lead_pred_slot = '0;
      lead_act_slot = '0;
      for (int i = 0; i < CELLS; i++) tally_matrix[i] = '0;
      for (int i = 0; i < MAX_CLASSES; i++) begin
         miss_by_actual[i] = '0;
         wrong_by_predicted[i] = '0;
      end
      events_counted = '0;
      diagonal_counted = '0;
      overflow_seen = 1'b0;
   endtask

   // A counter that has reached all ones stays there and raises the flag.
   function automatic logic [COUNT_W-1:0] sat_bump(input logic [COUNT_W-1:0] c);
      if (&c) begin
         overflow_seen = 1'b1;
         return c;
      end
      return c + 1'b1;
   endfunction

   // Out-of-range settings are clamped to the supported span of classes.
   function automatic int classes_active();
      if (class_setting < NUM_CLASSES_MIN) return NUM_CLASSES_MIN;
      if (class_setting > MAX_CLASSES) return MAX_CLASSES;
      return int'(class_setting);
   endfunction

   task automatic tally_step(input func_type code,
                             input logic signed [SCORE_W-1:0] ps, as,
                             input logic [CLASS_W-1:0] ci, oi);
      rsp_type          reply;
      bit               has_reply;
      logic [CLASS_W-1:0] a, p;
      reply = '0;
      has_reply = 1'b1;
      case (code)
         FUNC_CLEAR: begin
            clear_tallies();
            has_reply = 1'b0;
         end
         FUNC_SCORE: begin
            // The first position always takes the lead; afterwards only a
            // strictly greater score does, so ties stay with the earlier one.
            if (slot == 0 || ps > lead_pred_score) begin
               lead_pred_score = ps;
               lead_pred_slot = CLASS_W'(slot);
            end
            if (slot == 0 || as > lead_act_score) begin
               lead_act_score = as;
               lead_act_slot = CLASS_W'(slot);
            end
            // Reaching or passing the last position ends the event, which
            // also covers a setting lowered while an event was under way.
            if (slot + 1 < classes_active()) begin
               slot++;
               has_reply = 1'b0;
            end else begin
               slot = 0;
               a = lead_act_slot;
               p = lead_pred_slot;
               tally_matrix[{a, p}] = sat_bump(tally_matrix[{a, p}]);
               if (a == p) begin
                  diagonal_counted = sat_bump(diagonal_counted);
               end else begin
                  miss_by_actual[a] = sat_bump(miss_by_actual[a]);
                  wrong_by_predicted[p] = sat_bump(wrong_by_predicted[p]);
               end
               events_counted = sat_bump(events_counted);
               reply.kind = KIND_EVENT;
               reply.actual_class = a;
               reply.predicted_class = p;
               reply.cell_count = tally_matrix[{a, p}];
            end
         end
         FUNC_QUERY_CLASS: begin
            reply.kind = KIND_CLASS;
            reply.actual_class = ci;
            reply.predicted_class = ci;
            reply.cell_count = tally_matrix[{ci, ci}];
            reply.correct_count = tally_matrix[{ci, ci}];
            reply.row_miss_count = miss_by_actual[ci];
            reply.col_wrong_count = wrong_by_predicted[ci];
         end
         default: begin
            reply.kind = KIND_CELL;
            reply.actual_class = ci;
            reply.predicted_class = oi;
            reply.cell_count = tally_matrix[{ci, oi}];
         end
      endcase
      if (has_reply) begin
         reply.total_count = events_counted;
         reply.correct_total = diagonal_counted;
         reply.saturated = overflow_seen;
         tally_replies = {tally_replies, reply};
      end
   endtask

   // ------------------------------------------------------------------------
   // Request side. A word is offered at a falling edge after an optional
   // random gap and is accepted at the first rising edge with full low. push
   // stays high after acceptance so that the next word can follow at once;
   // settle_block lowers it when the stream pauses.
   // ------------------------------------------------------------------------
   task automatic send_word(input func_type code,
                            input logic signed [SCORE_W-1:0] ps, as,
                            input logic [CLASS_W-1:0] ci, oi);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
      @(negedge clock);
      repeat (gap) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_func <= code;
      req_predicted_score <= ps;
      req_actual_score <= as;
      req_class_index <= ci;
      req_other_index <= oi;
      do @(posedge clock); while (full !== 1'b0);
      words_sent++;
      tally_step(code, ps, as, ci, oi);
   endtask

   // Extremes, a narrow band around zero to force ties, and the full range.
   function automatic logic signed [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 9))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2, 3:    return SCORE_W'(int'($urandom_range(0, 6)) - 3);
         default: return SCORE_W'($urandom);
      endcase
   endfunction

   // Completes the event in progress with random scores, sometimes slipping
   // a query in between two positions.
   task automatic send_score_event();
      int remaining;
      remaining = classes_active() - slot;
      for (int i = 0; i < remaining; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_word(FUNC_QUERY_CLASS, pick_score(), pick_score(),
                      CLASS_W'($urandom), CLASS_W'($urandom));
         send_word(FUNC_SCORE, pick_score(), pick_score(),
                   CLASS_W'($urandom), CLASS_W'($urandom));
      end
   endtask

   // Stops offering words, waits for every predicted answer and then lets
   // the block finish any word that gives no answer.
   task automatic settle_block();
      @(negedge clock);
      push <= 1'b0;
      while (tally_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Register port. Writes only happen once the block has gone quiet.
   // ------------------------------------------------------------------------
   task automatic write_class_count(input logic [CSR_DATA_W-1:0] data);
      settle_block();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CLASSES_ADDR;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      class_setting = data[NUMC_W-1:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic read_class_count();
      logic [CSR_DATA_W-1:0] want;
      want = CSR_DATA_W'(class_setting);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CLASSES_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== want) begin
         mismatches++;
         $display("%0t: num_classes read back expected %0d, actual %0d",
                  $time, want, prdata);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Result side. The receiver lowers pop at random, or for a long counted
   // stretch when a hold-off has been requested.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_off_requested) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_off_requested = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(0, 99) >= pop_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                              input logic [COUNT_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d (0x%h), actual %0d (0x%h)",
                  $time, name, want, want, got, got);
      end
   endtask

   rsp_type oldest_reply;

   // Every accepted answer is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         replies_seen++;
         if (rsp_kind == KIND_EVENT) events_seen++;
         if (tally_replies.size() == 0) begin
            mismatches++;
            $display("%0t: answer of kind %0d arrived with none expected",
                     $time, rsp_kind);
         end else begin
            oldest_reply = tally_replies.pop_front();
            check_field("kind", 32'(oldest_reply.kind), 32'(rsp_kind));
            check_field("actual_class", 32'(oldest_reply.actual_class),
                        32'(rsp_actual_class));
            check_field("predicted_class", 32'(oldest_reply.predicted_class),
                        32'(rsp_predicted_class));
            check_field("cell_count", oldest_reply.cell_count, rsp_cell_count);
            check_field("correct_count", oldest_reply.correct_count,
                        rsp_correct_count);
            check_field("row_miss_count", oldest_reply.row_miss_count,
                        rsp_row_miss_count);
            check_field("col_wrong_count", oldest_reply.col_wrong_count,
                        rsp_col_wrong_count);
            check_field("total_count", oldest_reply.total_count, rsp_total_count);
            check_field("correct_total", oldest_reply.correct_total,
                        rsp_correct_total);
            check_field("saturated", 32'(oldest_reply.saturated),
                        32'(rsp_saturated));
         end
      end
   end

   // Watchdog: any accepted word on any port counts as progress.
   always @(posedge clock) begin
      if (push && full) stalled_cycles <= stalled_cycles + 1;
      if (reset || (push && !full) || (pop && !empty) || (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timed out after %0d cycles without progress.", quiet_cycles);
         $display("confusion_matrix_accumulator verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Reset value first, then the two ends of the field, then sixteen with the bits above the field set.
   task automatic test_register_access();
      read_class_count();
      write_class_count(32'd31);
      read_class_count();
      write_class_count(32'd0);
      read_class_count();
      write_class_count(32'hffff_ffe0 | 32'd16);
      read_class_count();
   endtask

   // Two classes: extreme scores, ties and the strictly-greater rule, then
   // every kind of query including a cell far beyond the classes in use.
   task automatic test_argmax_rules();
      write_class_count(32'd2);
      send_word(FUNC_SCORE, 16'sh7fff, 16'sh8000, 4'h0, 4'h0);
      send_word(FUNC_SCORE, 16'sh8000, 16'sh7fff, 4'hf, 4'hf);
      send_word(FUNC_SCORE, 16'sh0100, -16'sd1, 4'h5, 4'ha);
      send_word(FUNC_SCORE, 16'sh0100, -16'sd1, 4'ha, 4'h5);
      send_word(FUNC_SCORE, 16'sh8000, 16'sh8000, 4'h0, 4'h0);
      send_word(FUNC_SCORE, 16'sh8001, 16'sh8000, 4'h0, 4'h0);
      send_word(FUNC_QUERY_CLASS, '0, '0, 4'h0, 4'hf);
      send_word(FUNC_QUERY_CLASS, '0, '0, 4'h1, 4'h0);
      send_word(FUNC_QUERY_CELL, '0, '0, 4'h1, 4'h0);
      send_word(FUNC_QUERY_CELL, 16'shffff, 16'shffff, 4'hf, 4'hf);
   endtask

   // A setting of zero behaves as two classes.
   task automatic test_class_limits();
      write_class_count(32'd0);
      send_word(FUNC_SCORE, -16'sd1, -16'sd2, 4'h3, 4'h3);
      send_word(FUNC_SCORE, 16'sd0, -16'sd3, 4'h3, 4'h3);
   endtask

   // Five positions in with sixteen classes, the setting drops to three, so
   // the next position closes the event. Both winners lie beyond the new
   // class count and must still be reported and stored.
   task automatic test_shrink_mid_event();
      write_class_count(32'd16);
      send_word(FUNC_SCORE, 16'sd1, 16'sd0, 4'h0, 4'h0);
      send_word(FUNC_SCORE, 16'sd2, 16'sd0, 4'h0, 4'h0);
      send_word(FUNC_SCORE, 16'sd3, 16'sd0, 4'h0, 4'h0);
      send_word(FUNC_SCORE, 16'sd100, 16'sd0, 4'h0, 4'h0);
      send_word(FUNC_SCORE, 16'sd4, 16'sd50, 4'h0, 4'h0);
      write_class_count(32'd3);
      send_word(FUNC_SCORE, 16'sd0, 16'sd0, 4'h0, 4'h0);
      send_word(FUNC_QUERY_CLASS, '0, '0, 4'h4, 4'h0);
      send_word(FUNC_QUERY_CELL, '0, '0, 4'h4, 4'h3);
   endtask

   // A clear in the middle of an event drops the partial event as well as
   // every counter.
   task automatic test_clear_all();
      send_word(FUNC_SCORE, 16'sd9, 16'sd9, 4'h0, 4'h0);
      send_word(FUNC_CLEAR, '0, '0, 4'h0, 4'h0);
      send_word(FUNC_SCORE, 16'sd5, -16'sd5, 4'h0, 4'h0);
      send_word(FUNC_SCORE, 16'sd6, 16'sd7, 4'h0, 4'h0);
      send_word(FUNC_SCORE, 16'sd6, 16'sd7, 4'h0, 4'h0);
      send_word(FUNC_QUERY_CLASS, '0, '0, 4'h1, 4'h0);
   endtask

   // The receiver holds off for a long stretch while words keep coming, so
   // the answer queue and then the operation queue fill and full rises.
   task automatic test_backpressure();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      write_class_count(32'd2);
      @(posedge clock);
      hold_off_requested = 1'b1;
      repeat (10) begin
         send_score_event();
         send_word(FUNC_QUERY_CLASS, pick_score(), pick_score(),
                   CLASS_W'($urandom), CLASS_W'($urandom));
         send_word(FUNC_QUERY_CELL, pick_score(), pick_score(),
                   CLASS_W'($urandom), CLASS_W'($urandom));
      end
   endtask

   // Mostly whole events with random scores, mixed with queries, stray
   // score words that shift the event boundaries and the odd clear. Each
   // phase has its own class setting; four idling patterns take turns.
   task automatic test_random_traffic();
      int settings [8] = '{2, 16, 5, 31, 0, 17, 1, 9};
      int send_pcts [4] = '{0, 67, 0, 11};
      int pop_pcts [4] = '{0, 0, 67, 11};
      int phase_end;
      int pick;
      for (int ph = 0; ph < 8; ph++) begin
         write_class_count({$urandom} & ~32'h1f | 32'(settings[ph]));
         read_class_count();
         send_idle_pct = send_pcts[ph % 4];
         pop_stall_pct = pop_pcts[ph % 4];
         phase_end = words_sent + WORDS_PER_PHASE;
         while (words_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
               send_score_event();
            else if (pick < 82)
               send_word(FUNC_QUERY_CLASS, pick_score(), pick_score(),
                         CLASS_W'($urandom), CLASS_W'($urandom));
            else if (pick < 94)
               send_word(FUNC_QUERY_CELL, pick_score(), pick_score(),
                         CLASS_W'($urandom), CLASS_W'($urandom));
            else if (pick < 98)
               send_word(FUNC_SCORE, pick_score(), pick_score(),
                         CLASS_W'($urandom), CLASS_W'($urandom));
            else
               send_word(FUNC_CLEAR, pick_score(), pick_score(),
                         CLASS_W'($urandom), CLASS_W'($urandom));
         end
      end
   endtask

   initial begin
      clear_tallies();
      class_setting = NUM_CLASSES_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_access();
      send_idle_pct = 11;
      pop_stall_pct = 11;
      test_argmax_rules();
      test_class_limits();
      test_shrink_mid_event();
      test_clear_all();
      test_backpressure();
      test_random_traffic();
      settle_block();

      $display("Sent %0d request words; checked %0d answers, %0d of them event commits.",
               words_sent, replies_seen, events_seen);
      $display("Class settings 0 to 31 exercised; request side held back for %0d cycles.",
               stalled_cycles);
      if (mismatches == 0) begin
         $display("confusion_matrix_accumulator verification clean");
      end else begin
         $display("confusion_matrix_accumulator verification failed");
      end
      $finish;
   end

endmodule
